// ===== sv/utf8d_pkg.sv =====
package utf8d_pkg;

    localparam longint unsigned MAX_STRING_BYTES = 64'd65536;

    localparam int CP_W  = 21;
    localparam int ST_W  = 3;
    localparam int OFF_W = 16;

    localparam logic [OFF_W-1:0] OFFSET_CAP =
        ((MAX_STRING_BYTES - 64'd1) > 64'd65535) ? 16'hFFFF
                                                 : OFF_W'(MAX_STRING_BYTES - 64'd1);

    localparam logic [CP_W-1:0] MAX_POINT = 21'h10FFFF;

    typedef enum logic [ST_W-1:0] {
        ST_CHAR      = 3'd0,
        ST_END       = 3'd1,
        ST_BAD_LEAD  = 3'd2,
        ST_TRUNC     = 3'd3,
        ST_BAD_TRAIL = 3'd4,
        ST_OVERLONG  = 3'd5,
        ST_BAD_POINT = 3'd6
    } t_status;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        t_status          status;
        logic [OFF_W-1:0] stop_offset;
    } t_result;

endpackage

// ===== sv/utf8_to_utf32_decoder.sv =====
// UTF-8 to UTF-32 decoder with validation.
// Input channel: i_valid / o_stall carry one byte of a zero-terminated string
// per item on i_in_byte. Output channel: o_valid / i_stall carry one result:
// o_code_point, o_status (char, string end, or one of five faults) and
// o_stop_offset (byte index where decoding stopped, saturating at 65535).
// A byte is registered on acceptance into the input register and decoded from
// there straight into the output register once the output register is free.
// Lead and middle trail bytes give no result. Throughput is one byte per cycle
// while the receiver does not stall; the sequence state (partial code point,
// trail count, byte index) is updated in one pass per byte.
// When the receiver stalls, the result holds in the output register and the
// next byte waits in the input register; o_stall rises only once both are
// full and the output is stalled.
// After a fault, bytes are dropped without result up to and including the
// terminator. Synchronous active-low reset empties both registers and
// returns the decoder to expecting a lead byte at offset 0.
module utf8_to_utf32_decoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_in_byte,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [utf8d_pkg::CP_W-1:0]  o_code_point,
    output logic [utf8d_pkg::ST_W-1:0]  o_status,
    output logic [utf8d_pkg::OFF_W-1:0] o_stop_offset
);
    import utf8d_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    logic       out_free;
    logic       consume;
    logic       emit;
    t_result    res;

    assign out_free = !r_out_valid || !i_stall;
    assign consume  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    utf8d_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (consume),
        .i_byte  (r_in_byte),
        .o_emit  (emit),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && emit) begin
            r_out <= res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_code_point  = r_out.code_point;
    assign o_status      = r_out.status;
    assign o_stop_offset = r_out.stop_offset;

endmodule

// ===== sv/utf8d_decode.sv =====
module utf8d_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [7:0]        i_byte,
    output logic              o_emit,
    output utf8d_pkg::t_result o_res
);
    import utf8d_pkg::*;

    logic [CP_W-1:0]  r_accum, n_accum;
    logic [1:0]       r_trail, n_trail;
    logic [2:0]       r_seq, n_seq;
    logic [OFF_W-1:0] r_idx, n_idx;
    logic             r_halt, n_halt;

    logic [OFF_W-1:0] idx_adv;
    logic [CP_W-1:0]  cp_next;
    logic [1:0]       back;
    logic [OFF_W-1:0] lead_off;
    logic             overlong;

    assign idx_adv  = (r_idx < OFFSET_CAP) ? r_idx + 16'd1 : r_idx;
    assign cp_next  = {r_accum[CP_W-7:0], i_byte[5:0]};
    assign back     = 2'(r_seq - 3'd1);
    assign lead_off = (r_idx >= {14'd0, back}) ? r_idx - {14'd0, back} : '0;
    assign overlong = (cp_next <= 21'h00007F && r_seq > 3'd1) ||
                      (cp_next <= 21'h0007FF && r_seq > 3'd2) ||
                      (cp_next <= 21'h00FFFF && r_seq > 3'd3);

    always_comb begin
        n_accum = r_accum;
        n_trail = r_trail;
        n_seq   = r_seq;
        n_idx   = r_idx;
        n_halt  = r_halt;
        o_emit  = 1'b0;
        o_res   = '{code_point: '0, status: ST_CHAR, stop_offset: '0};

        if (r_halt) begin
            if (i_byte == 8'd0) begin
                n_accum = '0;
                n_trail = '0;
                n_seq   = '0;
                n_idx   = '0;
                n_halt  = 1'b0;
            end
        end else if (r_trail == 2'd0) begin
            priority if (i_byte == 8'd0) begin
                o_emit            = 1'b1;
                o_res.status      = ST_END;
                o_res.stop_offset = r_idx;
                n_accum = '0;
                n_trail = '0;
                n_seq   = '0;
                n_idx   = '0;
            end else if (i_byte[7] == 1'b0) begin
                o_emit           = 1'b1;
                o_res.code_point = {13'd0, i_byte};
                n_idx            = idx_adv;
            end else if (i_byte[7:5] == 3'b110) begin
                n_accum = {16'd0, i_byte[4:0]};
                n_seq   = 3'd2;
                n_trail = 2'd1;
                n_idx   = idx_adv;
            end else if (i_byte[7:4] == 4'b1110) begin
                n_accum = {17'd0, i_byte[3:0]};
                n_seq   = 3'd3;
                n_trail = 2'd2;
                n_idx   = idx_adv;
            end else if (i_byte[7:3] == 5'b11110) begin
                n_accum = {18'd0, i_byte[2:0]};
                n_seq   = 3'd4;
                n_trail = 2'd3;
                n_idx   = idx_adv;
            end else begin
                o_emit            = 1'b1;
                o_res.status      = ST_BAD_LEAD;
                o_res.stop_offset = r_idx;
                n_accum = '0;
                n_trail = '0;
                n_seq   = '0;
                n_halt  = 1'b1;
            end
        end else begin
            priority if (i_byte == 8'd0) begin
                o_emit            = 1'b1;
                o_res.status      = ST_TRUNC;
                o_res.stop_offset = r_idx;
                n_accum = '0;
                n_trail = '0;
                n_seq   = '0;
                n_idx   = '0;
            end else if (i_byte[7:6] != 2'b10) begin
                o_emit            = 1'b1;
                o_res.status      = ST_BAD_TRAIL;
                o_res.stop_offset = r_idx;
                n_accum = '0;
                n_trail = '0;
                n_seq   = '0;
                n_halt  = 1'b1;
            end else if (r_trail != 2'd1) begin
                n_accum = cp_next;
                n_trail = r_trail - 2'd1;
                n_idx   = idx_adv;
            end else begin
                o_emit  = 1'b1;
                n_accum = '0;
                n_trail = '0;
                n_seq   = '0;
                priority if (overlong) begin
                    o_res.status      = ST_OVERLONG;
                    o_res.stop_offset = lead_off;
                    n_halt            = 1'b1;
                end else if (cp_next > MAX_POINT) begin
                    o_res.status      = ST_BAD_POINT;
                    o_res.stop_offset = lead_off;
                    n_halt            = 1'b1;
                end else begin
                    o_res.code_point = cp_next;
                    n_idx            = idx_adv;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= '0;
            r_trail <= '0;
            r_seq   <= '0;
            r_idx   <= '0;
            r_halt  <= 1'b0;
        end else if (i_en) begin
            r_accum <= n_accum;
            r_trail <= n_trail;
            r_seq   <= n_seq;
            r_idx   <= n_idx;
            r_halt  <= n_halt;
        end
    end

endmodule

// ===== sv/utf8d_checker.sv =====
module utf8d_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [utf8d_pkg::CP_W-1:0]  o_code_point,
    input logic [utf8d_pkg::ST_W-1:0]  o_status,
    input logic [utf8d_pkg::OFF_W-1:0] o_stop_offset
);
    import utf8d_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_code_point)
                               && $stable(o_stop_offset))
        else $error("stalled result changed");

    a_char_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_CHAR |-> o_stop_offset == '0 && o_code_point <= MAX_POINT)
        else $error("char result with bad fields");

    a_fault_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_CHAR |-> o_code_point == '0)
        else $error("nonzero code point on end or fault");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("channels not empty after reset");

endmodule

bind utf8_to_utf32_decoder utf8d_checker u_utf8d_checker (.*);
